@@ src/meo_pkg.sv @@
// ----------------------------------------------------------------------------
// meo_pkg: shared definitions for the ellipse outline rasteriser
// Default sizes, command codes, quadrant codes and the pixel emit control
// word passed from the sequencer to the pixel generator.
// ----------------------------------------------------------------------------
package meo_pkg;

  localparam int RADIUS_BITS_DEF = 11;
  localparam int COORD_BITS_DEF  = 15;
  localparam int PIXEL_BITS      = 16;
  localparam int COLOR_BITS      = 8;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Order of the four symmetric pixels: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
  typedef enum logic [1:0] {
    QUAD_PP,
    QUAD_NP,
    QUAD_PN,
    QUAD_NN
  } quad_t;

  typedef struct packed {
    quad_t quad;
    logic  finish;
  } emit_t;

endpackage

@@ src/midpoint_ellipse_outline.sv @@
// ----------------------------------------------------------------------------
// midpoint_ellipse_outline: two-region midpoint ellipse outline rasteriser
// A start word latches centre, radii and colour and prepares region one; each
// step word emits the four mirrored pixels of the current point, then
// advances it. A start with both radii non-zero runs three products through
// the single shared multiplier. A step emits its pixels one per cycle while
// the pixel side is ready, then updates the point; the step that ends the
// ellipse has no update. The step that crosses into region two runs five
// more products on the same multiplier. A start with both radii zero emits
// one pixel at the centre; one radius zero emits nothing.
// ----------------------------------------------------------------------------
module midpoint_ellipse_outline #(
  parameter int RADIUS_BITS = meo_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = meo_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cmd_valid,
  output logic                                    cmd_ready,
  input  logic                                    command,
  input  logic signed [COORD_BITS-1:0]            center_x,
  input  logic signed [COORD_BITS-1:0]            center_y,
  input  logic        [RADIUS_BITS-1:0]           radius_x,
  input  logic        [RADIUS_BITS-1:0]           radius_y,
  input  logic        [meo_pkg::COLOR_BITS-1:0]   pen_color,
  output logic                                    pix_valid,
  input  logic                                    pix_ready,
  output logic signed [meo_pkg::PIXEL_BITS-1:0]   pixel_x,
  output logic signed [meo_pkg::PIXEL_BITS-1:0]   pixel_y,
  output logic        [meo_pkg::COLOR_BITS-1:0]   pixel_color,
  output logic                                    last_of_step,
  output logic                                    shape_done
);
  import meo_pkg::*;

  localparam int XW     = RADIUS_BITS + 1;
  localparam int YW     = RADIUS_BITS + 2;
  localparam int SQ_W   = 2 * RADIUS_BITS;
  localparam int MUL_W  = 2 * RADIUS_BITS + 4;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SL_W   = 3 * RADIUS_BITS + 4;
  localparam int D_W    = 4 * RADIUS_BITS + 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WB,
    S_EMIT,
    S_UPD
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2
  } phase_t;

  typedef enum logic [2:0] {
    OP_RXSQ,
    OP_RYSQ,
    OP_RXSQ_RY,
    OP_T2,
    OP_RY_T2,
    OP_U2,
    OP_RX_U2,
    OP_RXRY
  } op_t;

  state_t                   state;
  phase_t                   phase;
  op_t                      op;
  quad_t                    quad;
  logic                     finish;

  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic [COLOR_BITS-1:0]    ink;
  logic [RADIUS_BITS-1:0]   rad_x;
  logic [RADIUS_BITS-1:0]   rad_y;
  logic [SQ_W-1:0]          rx_sq;
  logic [SQ_W-1:0]          ry_sq;
  logic [XW-1:0]            cur_x;
  logic signed [YW-1:0]     cur_y;
  logic signed [SL_W-1:0]   slope_x;
  logic signed [SL_W-1:0]   slope_y;
  logic signed [D_W-1:0]    decision;
  logic [MUL_W-1:0]         tmp;
  logic signed [D_W-1:0]    acc;

  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic [PROD_W-1:0]        product;

  logic [YW-1:0]            t_val;
  logic signed [YW-1:0]     u_val;
  logic [YW-1:0]            u_abs;

  logic signed [SL_W-1:0]   ry2;
  logic signed [SL_W-1:0]   rx2;
  logic [XW-1:0]            cur_x_next;
  logic signed [YW-1:0]     cur_y_next;
  logic signed [SL_W-1:0]   slope_x_next;
  logic signed [SL_W-1:0]   slope_y_next;
  logic signed [D_W-1:0]    decision_next;
  logic                     d_neg;
  logic                     d_pos;
  logic                     y_end;

  emit_t                    emit;

  assign cmd_ready   = (state == S_IDLE);
  assign pix_valid   = (state == S_EMIT);
  assign pixel_color = ink;

  assign t_val = {cur_x, 1'b1};
  assign u_val = cur_y - YW'(1);
  assign u_abs = u_val[YW-1] ? YW'(1) : u_val;

  always_comb begin
    case (op)
      OP_RXSQ: begin
        mul_a = MUL_W'(rad_x);
        mul_b = MUL_W'(rad_x);
      end
      OP_RYSQ: begin
        mul_a = MUL_W'(rad_y);
        mul_b = MUL_W'(rad_y);
      end
      OP_RXSQ_RY: begin
        mul_a = MUL_W'(rx_sq);
        mul_b = MUL_W'(rad_y);
      end
      OP_T2: begin
        mul_a = MUL_W'(t_val);
        mul_b = MUL_W'(t_val);
      end
      OP_RY_T2: begin
        mul_a = MUL_W'(ry_sq);
        mul_b = tmp;
      end
      OP_U2: begin
        mul_a = MUL_W'(u_abs);
        mul_b = MUL_W'(u_abs);
      end
      OP_RX_U2: begin
        mul_a = MUL_W'(rx_sq);
        mul_b = tmp;
      end
      OP_RXRY: begin
        mul_a = MUL_W'(rx_sq);
        mul_b = MUL_W'(ry_sq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  meo_mul #(
    .WIDTH (MUL_W)
  ) u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  // Advance one point of the current region
  assign ry2   = SL_W'({ry_sq, 1'b0});
  assign rx2   = SL_W'({rx_sq, 1'b0});
  assign d_neg = decision[D_W-1];
  assign d_pos = !decision[D_W-1] && (decision != '0);
  assign y_end = cur_y[YW-1] || (cur_y == '0);

  always_comb begin
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    slope_x_next  = slope_x;
    slope_y_next  = slope_y;
    decision_next = decision;
    if (phase == PH_R1) begin
      cur_x_next   = cur_x + XW'(1);
      slope_x_next = slope_x + ry2;
      if (d_neg) begin
        decision_next = decision + D_W'(ry_sq) + D_W'(slope_x_next);
      end else begin
        cur_y_next    = cur_y - YW'(1);
        slope_y_next  = slope_y - rx2;
        decision_next = decision + D_W'(ry_sq) + D_W'(slope_x_next) - D_W'(slope_y_next);
      end
    end else begin
      cur_y_next   = cur_y - YW'(1);
      slope_y_next = slope_y - rx2;
      if (d_pos) begin
        decision_next = decision + D_W'(rx_sq) - D_W'(slope_y_next);
      end else begin
        cur_x_next    = cur_x + XW'(1);
        slope_x_next  = slope_x + ry2;
        decision_next = decision + D_W'(rx_sq) - D_W'(slope_y_next) + D_W'(slope_x_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      phase  <= PH_IDLE;
      op     <= OP_RXSQ;
      quad   <= QUAD_PP;
      finish <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (command == CMD_START) begin
              origin_x <= center_x;
              origin_y <= center_y;
              ink      <= pen_color;
              rad_x    <= radius_x;
              rad_y    <= radius_y;
              phase    <= PH_IDLE;
              if (radius_x == '0 && radius_y == '0) begin
                cur_x  <= '0;
                cur_y  <= '0;
                quad   <= QUAD_NN;
                finish <= 1'b1;
                state  <= S_EMIT;
              end else if (radius_x != '0 && radius_y != '0) begin
                op    <= OP_RXSQ;
                state <= S_ISSUE;
              end
            end else if (phase != PH_IDLE) begin
              quad   <= QUAD_PP;
              finish <= (phase == PH_R2) && y_end;
              state  <= S_EMIT;
            end
          end
        end
        S_ISSUE: begin
          state <= S_WB;
        end
        S_WB: begin
          case (op)
            OP_RXSQ: rx_sq <= SQ_W'(product);
            OP_RYSQ: ry_sq <= SQ_W'(product);
            OP_RXSQ_RY: begin
              slope_y  <= SL_W'({product, 1'b0});
              decision <= D_W'(ry_sq) - D_W'(product) + D_W'(rx_sq >> 2);
              cur_x    <= '0;
              cur_y    <= YW'(rad_y);
              slope_x  <= '0;
              phase    <= PH_R1;
            end
            OP_T2:    tmp <= MUL_W'(product);
            OP_RY_T2: acc <= D_W'(product >> 2);
            OP_U2:    tmp <= MUL_W'(product);
            OP_RX_U2: acc <= acc + D_W'(product);
            OP_RXRY: begin
              decision <= acc - D_W'(product);
              phase    <= PH_R2;
            end
            default: ;
          endcase
          if (op inside {OP_RXSQ_RY, OP_RXRY}) begin
            state <= S_IDLE;
          end else begin
            op    <= op_t'(op + 3'd1);
            state <= S_ISSUE;
          end
        end
        S_EMIT: begin
          if (pix_ready) begin
            if (quad == QUAD_NN) begin
              if (finish) begin
                phase <= PH_IDLE;
                state <= S_IDLE;
              end else begin
                state <= S_UPD;
              end
            end else begin
              quad <= quad_t'(quad + 2'd1);
            end
          end
        end
        S_UPD: begin
          cur_x    <= cur_x_next;
          cur_y    <= cur_y_next;
          slope_x  <= slope_x_next;
          slope_y  <= slope_y_next;
          decision <= decision_next;
          if (phase == PH_R1 && slope_x_next >= slope_y_next) begin
            op    <= OP_T2;
            state <= S_ISSUE;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign emit.quad   = quad;
  assign emit.finish = finish;

  meo_pix #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_pix (
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .cur_x        (cur_x),
    .cur_y        (cur_y),
    .emit         (emit),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_of_step (last_of_step),
    .shape_done   (shape_done)
  );

  a_upd_drawing: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (phase != PH_IDLE))
    else $error("update with no ellipse in progress");

  a_r2_y_positive: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && phase == PH_R2) |-> (!cur_y[YW-1] && cur_y != '0))
    else $error("region two advanced past the axis");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && shape_done) |-> last_of_step)
    else $error("shape end not on last pixel of step");

  a_no_extra_pixel: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready && last_of_step) |=> !pix_valid)
    else $error("pixel emitted after last of step");

  a_r2_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB && op == OP_RXRY) |=> (phase == PH_R2 && state == S_IDLE))
    else $error("region two set-up did not complete");

endmodule

@@ src/meo_mul.sv @@
// ----------------------------------------------------------------------------
// meo_mul: shared unsigned multiplier
// One registered product per cycle; every squared radius and the starting
// decision terms of both regions of the rasteriser go through this unit.
// ----------------------------------------------------------------------------
module meo_mul #(
  parameter int WIDTH = 2 * meo_pkg::RADIUS_BITS_DEF + 4
) (
  input  logic                 clk,
  input  logic [WIDTH-1:0]     a,
  input  logic [WIDTH-1:0]     b,
  output logic [2*WIDTH-1:0]   product
);

  always_ff @(posedge clk) begin
    product <= a * b;
  end

endmodule

@@ src/meo_pix.sv @@
// ----------------------------------------------------------------------------
// meo_pix: symmetric pixel generator
// Forms one of the four mirrored pixels of the current point about the
// centre, wrapped to the pixel width, with its end-of-step flags.
// ----------------------------------------------------------------------------
module meo_pix #(
  parameter int RADIUS_BITS = meo_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = meo_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0]            origin_x,
  input  logic signed [COORD_BITS-1:0]            origin_y,
  input  logic        [RADIUS_BITS:0]             cur_x,
  input  logic signed [RADIUS_BITS+1:0]           cur_y,
  input  meo_pkg::emit_t                          emit,
  output logic signed [meo_pkg::PIXEL_BITS-1:0]   pixel_x,
  output logic signed [meo_pkg::PIXEL_BITS-1:0]   pixel_y,
  output logic                                    last_of_step,
  output logic                                    shape_done
);
  import meo_pkg::*;

  localparam int SUM_W = ((COORD_BITS > RADIUS_BITS + 2) ? COORD_BITS : RADIUS_BITS + 2) + 1;
  localparam int EXT_W = (SUM_W > PIXEL_BITS) ? SUM_W : PIXEL_BITS;

  logic signed [EXT_W-1:0] ox;
  logic signed [EXT_W-1:0] oy;
  logic signed [EXT_W-1:0] dx;
  logic signed [EXT_W-1:0] dy;
  logic signed [EXT_W-1:0] sum_x;
  logic signed [EXT_W-1:0] sum_y;

  assign ox = EXT_W'(origin_x);
  assign oy = EXT_W'(origin_y);
  assign dx = EXT_W'($signed({1'b0, cur_x}));
  assign dy = EXT_W'(cur_y);

  assign sum_x = (emit.quad inside {QUAD_NP, QUAD_NN}) ? ox - dx : ox + dx;
  assign sum_y = (emit.quad inside {QUAD_PN, QUAD_NN}) ? oy - dy : oy + dy;

  assign pixel_x      = sum_x[PIXEL_BITS-1:0];
  assign pixel_y      = sum_y[PIXEL_BITS-1:0];
  assign last_of_step = (emit.quad == QUAD_NN);
  assign shape_done   = (emit.quad == QUAD_NN) && emit.finish;

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the midpoint ellipse outline rasteriser
// Start and step words go in over the command channel. A predictor of the
// two-region midpoint walk turns each accepted word into the pixels it should
// produce. Every pixel taken from the block is checked against the oldest of
// those. The run starts with a directed set: degenerate radii, full-size
// radii, extreme centres and colours, steps while idle and restarts while
// drawing. After that come mostly complete small ellipses, a few large ones
// cut short, degenerate starts and random stepping, with random gaps on both channels.
// ----------------------------------------------------------------------------

typedef enum logic [1:0] {
  TRACE_IDLE,
  TRACE_ARC_ONE,
  TRACE_ARC_TWO
} trace_phase_t;

typedef struct packed {
  logic signed [meo_pkg::PIXEL_BITS-1:0] x;
  logic signed [meo_pkg::PIXEL_BITS-1:0] y;
  logic        [meo_pkg::COLOR_BITS-1:0] ink;
  logic                                  last_px;
  logic                                  done;
} pixel_t;

class ellipse_tracker;
  pixel_t       pending_pixels[$];
  trace_phase_t phase;
  longint       org_x, org_y, rx_sq, ry_sq, walk_x, walk_y, slope_x, slope_y, dval;
  logic [7:0]   ink;
  int           errors;

  function new();
    phase   = TRACE_IDLE;
    org_x   = 0;
    org_y   = 0;
    rx_sq   = 0;
    ry_sq   = 0;
    walk_x  = 0;
    walk_y  = 0;
    slope_x = 0;
    slope_y = 0;
    dval    = 0;
    ink     = '0;
    errors  = 0;
  endfunction

  function bit idle();
    return phase == TRACE_IDLE;
  endfunction

  function int pending();
    return pending_pixels.size();
  endfunction

  function void push_pixel(longint x, longint y, bit last_px, bit done);
    pixel_t p;
    p.x       = x[15:0];
    p.y       = y[15:0];
    p.ink     = ink;
    p.last_px = last_px;
    p.done    = done;
    pending_pixels.push_back(p);
  endfunction

  function void push_quad(bit done);
    push_pixel(org_x + walk_x, org_y + walk_y, 1'b0, 1'b0);
    push_pixel(org_x - walk_x, org_y + walk_y, 1'b0, 1'b0);
    push_pixel(org_x + walk_x, org_y - walk_y, 1'b0, 1'b0);
    push_pixel(org_x - walk_x, org_y - walk_y, 1'b1, done);
  endfunction

  function void note_word(logic cmd, logic signed [14:0] cx, logic signed [14:0] cy,
                          logic [10:0] rx, logic [10:0] ry, logic [7:0] col);
    longint rxl, ryl, t, u;
    if (cmd == meo_pkg::CMD_START) begin
      rxl   = rx;
      ryl   = ry;
      org_x = cx;
      org_y = cy;
      ink   = col;
      phase = TRACE_IDLE;
      if (rxl == 0 || ryl == 0) begin
        if (rxl == 0 && ryl == 0) push_pixel(org_x, org_y, 1'b1, 1'b1);
        return;
      end
      rx_sq   = rxl * rxl;
      ry_sq   = ryl * ryl;
      walk_x  = 0;
      walk_y  = ryl;
      slope_x = 0;
      slope_y = 2 * rx_sq * ryl;
      dval    = ry_sq - rx_sq * ryl + rx_sq / 4;
      phase   = TRACE_ARC_ONE;
      return;
    end
    case (phase)
      TRACE_ARC_ONE: begin
        push_quad(1'b0);
        walk_x++;
        slope_x += 2 * ry_sq;
        if (dval < 0) begin
          dval += ry_sq + slope_x;
        end else begin
          walk_y--;
          slope_y -= 2 * rx_sq;
          dval += ry_sq + slope_x - slope_y;
        end
        if (slope_x >= slope_y) begin
          t     = 2 * walk_x + 1;
          u     = walk_y - 1;
          dval  = ry_sq * t * t / 4 + rx_sq * u * u - rx_sq * ry_sq;
          phase = TRACE_ARC_TWO;
        end
      end
      TRACE_ARC_TWO: begin
        if (walk_y <= 0) begin
          push_quad(1'b1);
          phase = TRACE_IDLE;
        end else begin
          push_quad(1'b0);
          walk_y--;
          slope_y -= 2 * rx_sq;
          if (dval > 0) begin
            dval += rx_sq - slope_y;
          end else begin
            walk_x++;
            slope_x += 2 * ry_sq;
            dval += rx_sq - slope_y + slope_x;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_pixel(pixel_t got);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected pixel: x=%0d y=%0d ink=%0d last=%0b done=%0b",
                 got.x, got.y, got.ink, got.last_px, got.done);
      return;
    end
    want = pending_pixels.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.ink !== want.ink ||
        got.last_px !== want.last_px || got.done !== want.done) begin
      errors++;
      if (errors <= 10)
        $display("pixel mismatch: expected x=%0d y=%0d ink=%0d last=%0b done=%0b,",
                 want.x, want.y, want.ink, want.last_px, want.done,
                 " got x=%0d y=%0d ink=%0d last=%0b done=%0b",
                 got.x, got.y, got.ink, got.last_px, got.done);
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int RANDOM_WORDS = 420;
  localparam int TAIL_CYCLES  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  logic        command = meo_pkg::CMD_STEP;
  logic signed [14:0] center_x = '0;
  logic signed [14:0] center_y = '0;
  logic [10:0] radius_x = '0;
  logic [10:0] radius_y = '0;
  logic [7:0]  pen_color = '0;
  logic        pix_valid;
  logic        pix_ready = 1'b0;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [7:0]  pixel_color;
  logic        last_of_step;
  logic        shape_done;

  ellipse_tracker tracker = new();
  int             cycles = 0;
  int             drawn_words = 0;
  int             ready_left = 0;

  midpoint_ellipse_outline uut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .command      (command),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .pen_color    (pen_color),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .last_of_step (last_of_step),
    .shape_done   (shape_done)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[midpoint_ellipse_outline] ERROR");
      $finish;
    end
  end

  // take pixels; hold ready in random stretches of stalls and bursts
  always @(posedge clk) begin
    int r;
    if (!rst && pix_valid && pix_ready)
      tracker.check_pixel({pixel_x, pixel_y, pixel_color, last_of_step, shape_done});
    if (ready_left > 0) begin
      ready_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        ready_left = $urandom_range(1, 30);
        pix_ready <= 1'b1;
      end else if (r < 90) begin
        ready_left = $urandom_range(1, 3);
        pix_ready <= 1'b0;
      end else begin
        ready_left = $urandom_range(10, 40);
        pix_ready <= 1'b0;
      end
    end
  end

  function automatic int word_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  task automatic send_word(input logic cmd, input logic signed [14:0] cx,
                           input logic signed [14:0] cy, input logic [10:0] rx,
                           input logic [10:0] ry, input logic [7:0] col);
    int gap;
    gap = word_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command   <= cmd;
    center_x  <= cx;
    center_y  <= cy;
    radius_x  <= rx;
    radius_y  <= ry;
    pen_color <= col;
    do @(posedge clk); while (!cmd_ready);
    if (!(cmd == meo_pkg::CMD_STEP && tracker.idle())) drawn_words++;
    tracker.note_word(cmd, cx, cy, rx, ry, col);
  endtask

  task automatic step_word();
    send_word(meo_pkg::CMD_STEP, 15'($urandom), 15'($urandom), 11'($urandom),
              11'($urandom), 8'($urandom));
  endtask

  task automatic draw(input logic signed [14:0] cx, input logic signed [14:0] cy,
                      input logic [10:0] rx, input logic [10:0] ry,
                      input logic [7:0] col, input int max_steps);
    int n;
    n = 0;
    send_word(meo_pkg::CMD_START, cx, cy, rx, ry, col);
    while (!tracker.idle() && n < max_steps) begin
      step_word();
      n++;
    end
  endtask

  initial begin
    int r;
    logic [10:0] rx, ry;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    step_word();
    draw(-15'sd16384, 15'sd16383, 11'd0, 11'd0, 8'hff, 0);
    draw(15'sd100, -15'sd100, 11'd0, 11'd2047, 8'h01, 0);
    draw(-15'sd1, -15'sd1, 11'd2047, 11'd0, 8'h80, 0);
    step_word();
    draw(15'sd16383, -15'sd16384, 11'd2047, 11'd2047, 8'h00, 4);
    draw(-15'sd16384, 15'sd16383, 11'd1, 11'd2047, 8'haa, 3);
    draw(15'sd0, 15'sd0, 11'd1, 11'd1, 8'h55, 100);
    step_word();
    draw(15'sd5, -15'sd7, 11'd3, 11'd1, 8'h0f, 100);

    drawn_words = 0;
    while (drawn_words < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        rx = 11'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24));
        ry = 11'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24));
        draw(15'($urandom), 15'($urandom), rx, ry, 8'($urandom),
             ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 100000);
        if ($urandom_range(0, 6) == 0) step_word();
      end else if (r < 80) begin
        draw(15'($urandom), 15'($urandom), 11'($urandom), 11'($urandom), 8'($urandom),
             $urandom_range(1, 10));
      end else if (r < 88) begin
        rx = ($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(1, 2047));
        ry = (rx != 0 || $urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(1, 2047));
        draw(15'($urandom), 15'($urandom), rx, ry, 8'($urandom), 0);
      end else begin
        repeat ($urandom_range(1, 3)) step_word();
      end
    end
    cmd_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("[midpoint_ellipse_outline] OK");
    else
      $display("[midpoint_ellipse_outline] ERROR");
    $finish;
  end

endmodule
